>>> rtl/tpp_pkg.sv
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types and constants of the tty output postprocessor: character
// codes, delay rule codes, register indexes, configuration and command types.
// ----------------------------------------------------------------------------
package tpp_pkg;

   localparam int TAB_STOP_DEFAULT = 8;

   // register indexes
   localparam logic [2:0] REG_CRLF_MODE      = 3'd0;
   localparam logic [2:0] REG_UPPER_CASE     = 3'd1;
   localparam logic [2:0] REG_EXPAND_TABS    = 3'd2;
   localparam logic [2:0] REG_TILDE_TO_GRAVE = 3'd3;
   localparam logic [2:0] REG_NL_DELAY       = 3'd4;
   localparam logic [2:0] REG_TAB_DELAY      = 3'd5;
   localparam logic [2:0] REG_CR_DELAY       = 3'd6;
   localparam logic [2:0] REG_VT_DELAY       = 3'd7;

   // character codes
   localparam logic [6:0] CH_BS        = 7'h08;
   localparam logic [6:0] CH_TAB       = 7'h09;
   localparam logic [6:0] CH_LF        = 7'h0A;
   localparam logic [6:0] CH_VT        = 7'h0B;
   localparam logic [6:0] CH_FF        = 7'h0C;
   localparam logic [6:0] CH_CR        = 7'h0D;
   localparam logic [6:0] CH_SPACE     = 7'h20;
   localparam logic [6:0] CH_BACKSLASH = 7'h5C;
   localparam logic [6:0] CH_GRAVE     = 7'h60;
   localparam logic [6:0] CH_TILDE     = 7'h7E;
   localparam logic [6:0] CH_UPPER_A   = 7'h41;
   localparam logic [6:0] CH_UPPER_Z   = 7'h5A;
   localparam logic [6:0] CH_LOWER_A   = 7'h61;
   localparam logic [6:0] CH_LOWER_Z   = 7'h7A;
   localparam logic [6:0] CASE_OFFSET  = 7'h20;

   // escape pairs of an upper-case terminal
   localparam logic [6:0] CH_LBRACE    = 7'h7B;
   localparam logic [6:0] CH_RBRACE    = 7'h7D;
   localparam logic [6:0] CH_BAR       = 7'h7C;
   localparam logic [6:0] CH_LPAREN    = 7'h28;
   localparam logic [6:0] CH_RPAREN    = 7'h29;
   localparam logic [6:0] CH_BANG      = 7'h21;
   localparam logic [6:0] CH_CARET     = 7'h5E;
   localparam logic [6:0] CH_QUOTE     = 7'h27;

   // delay rule codes
   localparam logic [1:0] NL_DLY_SCALED = 2'd1;
   localparam logic [1:0] NL_DLY_FIXED  = 2'd2;
   localparam logic [1:0] TAB_DLY_ON    = 2'd1;
   localparam logic [1:0] CR_DLY_SHORT  = 2'd1;
   localparam logic [1:0] CR_DLY_LONG   = 2'd2;
   localparam logic [1:0] CR_DLY_COLUMN = 2'd3;

   // delay values
   localparam logic [7:0] NL_DELAY_MIN   = 8'd6;
   localparam logic [7:0] TAB_DELAY_MIN  = 8'd5;
   localparam logic [7:0] CR_DELAY_SHORT = 8'd5;
   localparam logic [7:0] CR_DELAY_LONG  = 8'd10;
   localparam logic [7:0] CR_DELAY_BASE  = 8'd9;
   localparam logic [7:0] VT_DELAY       = 8'd127;

   // result kinds
   localparam logic KIND_CHAR  = 1'b0;
   localparam logic KIND_DELAY = 1'b1;

   typedef struct packed {
      logic       crlf_mode;
      logic       upper_case_terminal;
      logic       expand_tabs;
      logic       tilde_to_grave;
      logic [1:0] newline_delay_mode;
      logic [1:0] tab_delay_mode;
      logic [1:0] return_delay_mode;
      logic       vertical_tab_delay;
   } cfg_type;

   // one classified transaction: an expanded tab, or one or two characters
   typedef struct packed {
      logic       tab_expand;
      logic       two;
      logic [6:0] char0;
      logic [6:0] char1;
   } cmd_type;

endpackage

>>> rtl/tpp_front.sv
// ----------------------------------------------------------------------------
// tpp_front
// Classifies one input character: tab expansion, CR LF, tilde mapping and
// upper-case terminal escapes. Produces a command for the back end.
// ----------------------------------------------------------------------------
module tpp_front (
   input  tpp_pkg::cfg_type cfg,
   input  logic [7:0]       char_in,
   output tpp_pkg::cmd_type cmd
);
   import tpp_pkg::*;

   logic [6:0] c;
   logic [6:0] mapped;
   logic       esc_hit;
   logic [6:0] esc_char;

   assign c      = char_in[6:0];
   assign mapped = (c == CH_TILDE && cfg.tilde_to_grave) ? CH_GRAVE : c;

   always_comb begin
      esc_hit  = 1'b1;
      esc_char = mapped;
      case (mapped)
         CH_LBRACE: esc_char = CH_LPAREN;
         CH_RBRACE: esc_char = CH_RPAREN;
         CH_BAR:    esc_char = CH_BANG;
         CH_TILDE:  esc_char = CH_CARET;
         CH_GRAVE:  esc_char = CH_QUOTE;
         default:   esc_hit  = 1'b0;
      endcase
   end

   always_comb begin
      cmd.tab_expand = 1'b0;
      cmd.two        = 1'b0;
      cmd.char0      = mapped;
      cmd.char1      = mapped;
      if (c == CH_TAB && cfg.expand_tabs) begin
         cmd.tab_expand = 1'b1;
      end else if (c == CH_LF && cfg.crlf_mode) begin
         cmd.two   = 1'b1;
         cmd.char0 = CH_CR;
         cmd.char1 = CH_LF;
      end else if (c == CH_TAB || c == CH_LF) begin
         cmd.char0 = c;
      end else if (cfg.upper_case_terminal) begin
         if (esc_hit) begin
            cmd.two   = 1'b1;
            cmd.char0 = CH_BACKSLASH;
            cmd.char1 = esc_char;
         end else if (mapped >= CH_UPPER_A && mapped <= CH_UPPER_Z) begin
            cmd.two   = 1'b1;
            cmd.char0 = CH_BACKSLASH;
         end else if (mapped >= CH_LOWER_A && mapped <= CH_LOWER_Z) begin
            cmd.char0 = mapped - CASE_OFFSET;
         end
      end
   end

endmodule

>>> rtl/tpp_queue.sv
// ----------------------------------------------------------------------------
// tpp_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tpp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tpp_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output tpp_pkg::cmd_type head_cmd
);
   import tpp_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/tpp_back.sv
// ----------------------------------------------------------------------------
// tpp_back
// Sequencer that carries out commands one result per cycle while the result
// register is free: characters, delay items and expanded tab spaces. Keeps
// the terminal column.
module tpp_back #(
   parameter int TAB_STOP = tpp_pkg::TAB_STOP_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  tpp_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   input  tpp_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_kind,
   output logic [7:0]       rsp_value,
   output logic             rsp_last
);
   import tpp_pkg::*;

   localparam int PW = $clog2(TAB_STOP);
   localparam int DW = $clog2(TAB_STOP + 1);

   typedef enum logic {PH_CHAR, PH_DELAY} phase_type;

   phase_type   phase_ff, phase_in;
   logic        idx_ff, idx_in;
   logic        first_ff, first_in;
   logic [3:0]  rem_ff, rem_in;
   logic [7:0]  delay_ff, delay_in;
   logic [7:0]  column_ff, column_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_value_ff, rsp_value_in;
   logic        rsp_last_ff, rsp_last_in;

   logic          out_free;
   logic [6:0]    cur;
   logic          more;
   logic [DW-1:0] stop_gap;
   logic [4:0]    dist_w;
   logic [3:0]    span;
   logic [3:0]    eff_rem;
   logic [7:0]    inc_col;
   logic [PW-1:0] inc_pos;
   logic [8:0]    tab_sum;
   logic [7:0]    tab_dly;
   logic [7:0]    char_col;
   logic [PW-1:0] char_pos;
   logic [7:0]    char_delay;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      cur      = idx_ff ? cmd.char1 : cmd.char0;
      more     = cmd.two && !idx_ff;
      stop_gap = DW'(TAB_STOP) - DW'(pos_ff);
      dist_w   = 5'(stop_gap);
      span     = (dist_w > 5'd8) ? 4'd8 : dist_w[3:0];
      eff_rem  = first_ff ? span : rem_ff;
      inc_col  = column_ff + 8'd1;
      inc_pos  = (column_ff == 8'hFF || pos_ff == PW'(TAB_STOP - 1)) ? '0 : pos_ff + PW'(1);
      tab_sum  = {1'b0, column_ff} + 9'(stop_gap);
      tab_dly  = 8'(dist_w) + 8'd1;
   end

   // column movement and delay of one sent character
   always_comb begin
      char_col   = column_ff;
      char_pos   = pos_ff;
      char_delay = 8'd0;
      case (cur)
         CH_BS: begin
            if (column_ff != 8'd0) begin
               char_col = column_ff - 8'd1;
               char_pos = (pos_ff == '0) ? PW'(TAB_STOP - 1) : pos_ff - PW'(1);
            end
         end
         CH_TAB: begin
            if (cfg.tab_delay_mode == TAB_DLY_ON && tab_dly >= TAB_DELAY_MIN) begin
               char_delay = tab_dly;
            end
            char_col = tab_sum[7:0];
            char_pos = tab_sum[8] ? tab_sum[PW-1:0] : '0;
         end
         CH_LF: begin
            if (cfg.newline_delay_mode == NL_DLY_SCALED) begin
               if (column_ff != 8'd0) begin
                  char_delay = ({4'd0, column_ff[7:4]} < NL_DELAY_MIN) ?
                               NL_DELAY_MIN : {4'd0, column_ff[7:4]};
               end
            end else if (cfg.newline_delay_mode == NL_DLY_FIXED) begin
               char_delay = NL_DELAY_MIN;
            end
            if (!cfg.crlf_mode) begin
               char_col = 8'd0;
               char_pos = '0;
            end
         end
         CH_VT, CH_FF: begin
            if (cfg.vertical_tab_delay) begin
               char_delay = VT_DELAY;
            end
         end
         CH_CR: begin
            case (cfg.return_delay_mode)
               CR_DLY_SHORT:  char_delay = CR_DELAY_SHORT;
               CR_DLY_LONG:   char_delay = CR_DELAY_LONG;
               CR_DLY_COLUMN: char_delay = (column_ff < CR_DELAY_BASE) ?
                                           CR_DELAY_BASE - column_ff : 8'd0;
               default:       char_delay = 8'd0;
            endcase
            char_col = 8'd0;
            char_pos = '0;
         end
         default: begin
            if (cur >= CH_SPACE && cur <= CH_TILDE) begin
               char_col = inc_col;
               char_pos = inc_pos;
            end
         end
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      first_in     = first_ff;
      rem_in       = rem_ff;
      delay_in     = delay_ff;
      column_in    = column_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      cmd_pop      = 1'b0;
      if (cmd_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_CHAR;
         rsp_last_in  = 1'b0;
         if (cmd.tab_expand) begin
            rsp_value_in = {1'b0, CH_SPACE};
            rsp_last_in  = (eff_rem == 4'd1);
            column_in    = inc_col;
            pos_in       = inc_pos;
            rem_in       = eff_rem - 4'd1;
            first_in     = (eff_rem == 4'd1);
            cmd_pop      = (eff_rem == 4'd1);
         end else if (phase_ff == PH_CHAR) begin
            rsp_value_in = {1'b0, cur};
            column_in    = char_col;
            pos_in       = char_pos;
            if (char_delay != 8'd0) begin
               delay_in = char_delay;
               phase_in = PH_DELAY;
            end else begin
               rsp_last_in = !more;
               idx_in      = more;
               cmd_pop     = !more;
            end
         end else begin
            rsp_kind_in  = KIND_DELAY;
            rsp_value_in = delay_ff;
            phase_in     = PH_CHAR;
            rsp_last_in  = !more;
            idx_in       = more;
            cmd_pop      = !more;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rem_ff       <= rem_in;
      delay_ff     <= delay_in;
      if (reset) begin
         phase_ff     <= PH_CHAR;
         idx_ff       <= 1'b0;
         first_ff     <= 1'b1;
         column_ff    <= 8'd0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         first_ff     <= first_in;
         column_ff    <= column_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/tty_output_postprocessor.sv
// ----------------------------------------------------------------------------
// tty_output_postprocessor
// Output post-processing for a character terminal.
//
// req_char_in carries one character per transaction (bit 7 ignored). Each
// transaction yields one to eight rsp_ transactions: characters (kind 0) or
// delay ticks (kind 1), rsp_last set on the final one of the input.
// A front end classifies the character and writes a two-entry command
// queue; a back end sequencer issues one result per cycle while the result
// register is free and keeps the column. Each accepted character passes
// through the queue and its results leave through the result register.
// req_stall rises while the queue is full. When rsp_stall is high the
// result register holds and the back end waits; the front end keeps
// accepting until the queue fills. Reset clears the column, the queue and
// the result register and loads the register defaults (CR LF on, all else
// off). Registers sit at 4*index on the APB port; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module tty_output_postprocessor #(
   parameter int TAB_STOP = tpp_pkg::TAB_STOP_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_value,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import tpp_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       csr_write;
   logic [2:0] csr_index;
   cmd_type    front_cmd;
   cmd_type    head_cmd;
   logic       q_full;
   logic       head_valid;
   logic       cmd_pop;
   logic       req_push;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[4:2];
   assign req_stall = q_full;
   assign req_push  = req_valid && !q_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_CRLF_MODE:      cfg_in.crlf_mode           = pwdata[0];
            REG_UPPER_CASE:     cfg_in.upper_case_terminal = pwdata[0];
            REG_EXPAND_TABS:    cfg_in.expand_tabs         = pwdata[0];
            REG_TILDE_TO_GRAVE: cfg_in.tilde_to_grave      = pwdata[0];
            REG_NL_DELAY:       cfg_in.newline_delay_mode  = pwdata[1:0];
            REG_TAB_DELAY:      cfg_in.tab_delay_mode      = pwdata[1:0];
            REG_CR_DELAY:       cfg_in.return_delay_mode   = pwdata[1:0];
            REG_VT_DELAY:       cfg_in.vertical_tab_delay  = pwdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      prdata = 32'd0;
      case (csr_index)
         REG_CRLF_MODE:      prdata = {31'd0, cfg_ff.crlf_mode};
         REG_UPPER_CASE:     prdata = {31'd0, cfg_ff.upper_case_terminal};
         REG_EXPAND_TABS:    prdata = {31'd0, cfg_ff.expand_tabs};
         REG_TILDE_TO_GRAVE: prdata = {31'd0, cfg_ff.tilde_to_grave};
         REG_NL_DELAY:       prdata = {30'd0, cfg_ff.newline_delay_mode};
         REG_TAB_DELAY:      prdata = {30'd0, cfg_ff.tab_delay_mode};
         REG_CR_DELAY:       prdata = {30'd0, cfg_ff.return_delay_mode};
         REG_VT_DELAY:       prdata = {31'd0, cfg_ff.vertical_tab_delay};
         default:            prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                     <= '0;
         cfg_ff.crlf_mode           <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tpp_front u_front (
      .cfg     (cfg_ff),
      .char_in (req_char_in),
      .cmd     (front_cmd)
   );

   tpp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .push_cmd   (front_cmd),
      .full       (q_full),
      .pop        (cmd_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   tpp_back #(
      .TAB_STOP (TAB_STOP)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (head_valid),
      .cmd       (head_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_kind  (rsp_kind),
      .rsp_value (rsp_value),
      .rsp_last  (rsp_last)
   );

   // a transaction that is not the last of its input is always followed
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("result run broken before last");

   a_delay_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DELAY |-> rsp_value != 8'd0)
      else $error("zero delay item issued");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tty output postprocessor. Characters are sent
// in bursts with random gaps while the result side stalls on patterns of its
// own. A behavioral predictor tracks the terminal column and the register
// settings, builds the expected characters and delay items per transaction,
// and each result transaction is checked in order. Phases run with directed
// characters first, then line-structured random text, under several register
// settings including all-zero and all-ones.
// ----------------------------------------------------------------------------
module testbench;
   import tpp_pkg::*;

   localparam int TAB_STOP   = TAB_STOP_DEFAULT;
   localparam int MAX_SPACES = 8;

   localparam logic [6:0] CH_DEL    = 7'h7F;

   localparam logic [1:0] NL_DLY_NONE    = 2'd0;
   localparam logic [1:0] NL_DLY_UNUSED  = 2'd3;
   localparam logic [1:0] TAB_DLY_NONE   = 2'd0;
   localparam logic [1:0] TAB_DLY_UNUSED = 2'd2;
   localparam logic [1:0] CR_DLY_NONE    = 2'd0;

   typedef struct packed {
      logic       kind;
      logic [7:0] value;
      logic       last;
   } tty_result_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       drain_first;
   } pending_char_type;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HOLD
   } stall_pattern_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_value;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = 5'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   cfg_type           tty_cfg;
   logic [7:0]        term_column;
   tty_result_type    step_out[$];
   tty_result_type    expected_output[$];
   pending_char_type  pending_chars[$];
   int                mismatch_count = 0;
   int                burst_left = 0;
   int                gap_left = 0;
   stall_pattern_type stall_pattern = STALL_NONE;
   int                pattern_left = 0;

   tty_output_postprocessor dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_char_in(req_char_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_value(rsp_value), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------
   function automatic void push_result(input logic kind, input logic [7:0] value);
      tty_result_type r;
      r.kind = kind;
      r.value = value;
      r.last = 1'b0;
      step_out.push_back(r);
   endfunction

   function automatic void send_tty_char(input logic [6:0] c);
      logic [7:0] delay;
      logic [7:0] stop_gap;
      delay = 8'd0;
      stop_gap = 8'(TAB_STOP - (term_column % TAB_STOP));
      push_result(KIND_CHAR, {1'b0, c});
      case (c)
         CH_BS: begin
            if (term_column != 0) term_column = term_column - 8'd1;
         end
         CH_TAB: begin
            if (tty_cfg.tab_delay_mode == TAB_DLY_ON) begin
               delay = stop_gap + 8'd1;
               if (delay < TAB_DELAY_MIN) delay = 8'd0;
            end
            term_column = term_column + stop_gap;
         end
         CH_LF: begin
            if (tty_cfg.newline_delay_mode == NL_DLY_SCALED) begin
               if (term_column != 0) begin
                  delay = term_column >> 4;
                  if (delay < NL_DELAY_MIN) delay = NL_DELAY_MIN;
               end
            end else if (tty_cfg.newline_delay_mode == NL_DLY_FIXED) begin
               delay = NL_DELAY_MIN;
            end
            if (!tty_cfg.crlf_mode) term_column = 8'd0;
         end
         CH_VT, CH_FF: begin
            if (tty_cfg.vertical_tab_delay) delay = VT_DELAY;
         end
         CH_CR: begin
            case (tty_cfg.return_delay_mode)
               CR_DLY_SHORT:  delay = CR_DELAY_SHORT;
               CR_DLY_LONG:   delay = CR_DELAY_LONG;
               CR_DLY_COLUMN: delay = (term_column < CR_DELAY_BASE) ?
                                      CR_DELAY_BASE - term_column : 8'd0;
               default:       delay = 8'd0;
            endcase
            term_column = 8'd0;
         end
         default: begin
            if (c >= CH_SPACE && c != CH_DEL) term_column = term_column + 8'd1;
         end
      endcase
      if (delay != 0) push_result(KIND_DELAY, delay);
   endfunction

   function automatic void send_escaped(input logic [6:0] c);
      send_tty_char(CH_BACKSLASH);
      send_tty_char(c);
   endfunction

   function automatic void predict_tty_output(input logic [7:0] raw);
      logic [6:0] c;
      logic [7:0] stop_gap;
      step_out.delete();
      c = raw[6:0];
      if (c == CH_TAB && tty_cfg.expand_tabs) begin
         stop_gap = 8'(TAB_STOP - (term_column % TAB_STOP));
         if (stop_gap > MAX_SPACES) stop_gap = 8'(MAX_SPACES);
         repeat (stop_gap) begin
            push_result(KIND_CHAR, {1'b0, CH_SPACE});
            term_column = term_column + 8'd1;
         end
      end else if (c == CH_LF && tty_cfg.crlf_mode) begin
         send_tty_char(CH_CR);
         send_tty_char(CH_LF);
      end else if (c == CH_TAB || c == CH_LF) begin
         send_tty_char(c);
      end else begin
         if (c == CH_TILDE && tty_cfg.tilde_to_grave) c = CH_GRAVE;
         if (tty_cfg.upper_case_terminal) begin
            case (c)
               CH_LBRACE: send_escaped(CH_LPAREN);
               CH_RBRACE: send_escaped(CH_RPAREN);
               CH_BAR:    send_escaped(CH_BANG);
               CH_TILDE:  send_escaped(CH_CARET);
               CH_GRAVE:  send_escaped(CH_QUOTE);
               default: begin
                  if (c >= CH_UPPER_A && c <= CH_UPPER_Z) send_escaped(c);
                  else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) send_tty_char(c - CASE_OFFSET);
                  else send_tty_char(c);
               end
            endcase
         end else begin
            send_tty_char(c);
         end
      end
      step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) expected_output.push_back(step_out[i]);
   endfunction

   // ------------------------------------------------------------------
   // request driver: bursts with random gaps
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_tty_output(req_char_in);
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_chars.size() > 0 &&
                         !(pending_chars[0].drain_first && expected_output.size() != 0)) begin
               req_valid <= 1'b1;
               req_char_in <= pending_chars[0].ch;
               void'(pending_chars.pop_front());
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left = burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // result monitor and stall pattern
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      tty_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_output.size() == 0) begin
               $display("%0t: unexpected result transaction kind %0h value %0h last %0h",
                        $time, rsp_kind, rsp_value, rsp_last);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = expected_output.pop_front();
               if (rsp_kind !== want.kind) begin
                  $display("%0t: kind mismatch, expected %0h actual %0h",
                           $time, want.kind, rsp_kind);
                  mismatch_count = mismatch_count + 1;
               end
               if (rsp_value !== want.value) begin
                  $display("%0t: value mismatch, expected %0h actual %0h",
                           $time, want.value, rsp_value);
                  mismatch_count = mismatch_count + 1;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last mismatch, expected %0h actual %0h",
                           $time, want.last, rsp_last);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
         if (pattern_left == 0) begin
            stall_pattern = stall_pattern_type'($urandom_range(0, 3));
            pattern_left = (stall_pattern == STALL_HOLD) ? $urandom_range(2, 20)
                                                         : $urandom_range(5, 60);
         end else begin
            pattern_left = pattern_left - 1;
         end
         case (stall_pattern)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: rsp_stall <= ((pattern_left % 8) < 6);
            default:        rsp_stall <= 1'b1;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic apply_config(input cfg_type c);
      write_reg(REG_CRLF_MODE,      {31'd0, c.crlf_mode});
      write_reg(REG_UPPER_CASE,     {31'd0, c.upper_case_terminal});
      write_reg(REG_EXPAND_TABS,    {31'd0, c.expand_tabs});
      write_reg(REG_TILDE_TO_GRAVE, {31'd0, c.tilde_to_grave});
      write_reg(REG_NL_DELAY,       {30'd0, c.newline_delay_mode});
      write_reg(REG_TAB_DELAY,      {30'd0, c.tab_delay_mode});
      write_reg(REG_CR_DELAY,       {30'd0, c.return_delay_mode});
      write_reg(REG_VT_DELAY,       {31'd0, c.vertical_tab_delay});
      tty_cfg = c;
   endtask

   task automatic wait_drained();
      while (pending_chars.size() != 0 || req_valid || expected_output.size() != 0)
         @(posedge clock);
   endtask

   function automatic void add_char(input logic [7:0] ch, input logic drain);
      pending_char_type p;
      p.ch = ch;
      p.drain_first = drain;
      pending_chars.push_back(p);
   endfunction

   function automatic logic [6:0] random_text_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return 7'($urandom_range(CH_SPACE, CH_TILDE));
      if (r < 42) begin
         case ($urandom_range(0, 4))
            0: return CH_LBRACE;
            1: return CH_RBRACE;
            2: return CH_BAR;
            3: return CH_TILDE;
            default: return CH_GRAVE;
         endcase
      end
      if (r < 67) return CH_TAB;
      if (r < 74) return CH_BS;
      if (r < 79) return ($urandom_range(0, 1) == 0) ? CH_VT : CH_FF;
      if (r < 85) return ($urandom_range(0, 3) == 0) ? CH_DEL : 7'($urandom_range(0, 31));
      if (r < 92) return 7'($urandom_range(0, 127));
      return ($urandom_range(0, 1) == 0) ? CH_LF : CH_CR;
   endfunction

   // text made of lines, mostly short, some long enough to wrap the column
   task automatic add_random_text(input int count);
      int n;
      int line_len;
      n = 0;
      while (n < count) begin
         line_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70)
                                                : $urandom_range(1, 12);
         repeat (line_len) begin
            if (n < count) begin
               add_char({1'($urandom_range(0, 1)), random_text_char()},
                        ($urandom_range(0, 39) == 0) || (n == count / 2));
               n = n + 1;
            end
         end
         if (n < count) begin
            add_char({1'($urandom_range(0, 1)),
                      ($urandom_range(0, 2) == 0) ? CH_CR : CH_LF}, 1'b0);
            n = n + 1;
         end
      end
   endtask

   initial begin
      logic [7:0] plain_chars[6] = '{8'h61, 8'hFF, 8'h0A, 8'h00, 8'h09, 8'h0D};
      logic [7:0] upper_chars[15] = '{8'h08, 8'h7B, 8'h7D, 8'h7C, 8'h7E, 8'hE0, 8'h41,
                                      8'h5A, 8'h61, 8'h7A, 8'h5B, 8'h09, 8'h0A, 8'h0B,
                                      8'h0D};
      logic [7:0] grave_chars[4] = '{8'h7E, 8'h09, 8'h8C, 8'h0A};
      cfg_type random_cfgs[6];

      tty_cfg = '{1'b1, 1'b0, 1'b0, 1'b0, NL_DLY_NONE, TAB_DLY_NONE, CR_DLY_NONE, 1'b0};
      term_column = 8'd0;
      random_cfgs[0] = '0;
      random_cfgs[1] = '1;
      random_cfgs[2] = '{1'b0, 1'b0, 1'b0, 1'b0, NL_DLY_SCALED, TAB_DLY_ON,
                         CR_DLY_SHORT, 1'b1};
      random_cfgs[3] = '{1'b1, 1'b1, 1'b0, 1'b1, NL_DLY_UNUSED, TAB_DLY_UNUSED,
                         CR_DLY_LONG, 1'b0};
      random_cfgs[4] = cfg_type'($urandom);
      random_cfgs[5] = cfg_type'($urandom);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plain_chars[i]) add_char(plain_chars[i], 1'b0);
      wait_drained();

      apply_config('{1'b1, 1'b1, 1'b1, 1'b0, NL_DLY_SCALED, TAB_DLY_ON,
                     CR_DLY_COLUMN, 1'b1});
      foreach (upper_chars[i]) add_char(upper_chars[i], 1'b0);
      wait_drained();

      apply_config('{1'b0, 1'b1, 1'b0, 1'b1, NL_DLY_FIXED, TAB_DLY_ON,
                     CR_DLY_LONG, 1'b0});
      foreach (grave_chars[i]) add_char(grave_chars[i], 1'b0);
      wait_drained();

      foreach (random_cfgs[i]) begin
         apply_config(random_cfgs[i]);
         add_random_text(46);
         wait_drained();
      end

      repeat (12) @(posedge clock);
      if (mismatch_count == 0 && expected_output.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("%0t: timeout with %0d results outstanding", $time, expected_output.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
